/* rtl/slm_pkg.sv */
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants for the sorted list merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package slm_pkg;

    localparam int DEFAULT_LIST_DEPTH = 16;
    localparam int DATA_W             = 32;

    typedef enum logic [1:0] {
        KIND_FIRST  = 2'd0,
        KIND_SECOND = 2'd1,
        KIND_START  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNSORTED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic    go;
        status_t code;
    } start_t;

endpackage

`default_nettype wire

/* rtl/slm_ram.sv */
// ----------------------------------------------------------------------------
// slm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/slm_merge.sv */
// ----------------------------------------------------------------------------
// slm_merge
// Merge sequencer: walks both list memories, emits one beat per cycle, unless
// the output stalls, into an output register, or a single error beat.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_merge #(
    parameter int LIST_DEPTH = slm_pkg::DEFAULT_LIST_DEPTH
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire slm_pkg::start_t                          start,
    input  wire logic [$clog2(LIST_DEPTH+1)-1:0]          cnt_a,
    input  wire logic [$clog2(LIST_DEPTH+1)-1:0]          cnt_b,
    output logic                                          busy,
    output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] raddr_a,
    output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] raddr_b,
    input  wire logic [slm_pkg::DATA_W-1:0]               rdata_a,
    input  wire logic [slm_pkg::DATA_W-1:0]               rdata_b,
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic [slm_pkg::DATA_W-1:0]                    out_value,
    output logic                                          out_last,
    output logic [1:0]                                    out_status
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PRIME = 4'b0010,
        S_RUN   = 4'b0100,
        S_ERR   = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              i_reg, i_next;
    logic [CW-1:0]              j_reg, j_next;
    logic [CW-1:0]              cnt_a_reg, cnt_b_reg;
    slm_pkg::status_t           code_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [slm_pkg::DATA_W-1:0] value_reg, value_next;
    logic                       last_reg, last_next;
    slm_pkg::status_t           status_reg, status_next;
    logic                       out_load;

    logic                       slot_free;
    logic                       a_done, b_done;
    logic                       pick_a;

    assign slot_free = !out_valid_reg || out_ready;
    assign a_done    = (i_reg == cnt_a_reg);
    assign b_done    = (j_reg == cnt_b_reg);
    assign pick_a    = b_done || (!a_done && ($signed(rdata_a) <= $signed(rdata_b)));

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        out_load    = 1'b0;
        value_next  = value_reg;
        last_next   = last_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start.go)
                begin
                    i_next = '0;
                    j_next = '0;
                    if (start.code == slm_pkg::ST_EMPTY || start.code == slm_pkg::ST_UNSORTED)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        state_next = S_PRIME;
                    end
                end
            end
            S_PRIME:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (slot_free)
                begin
                    out_load    = 1'b1;
                    status_next = code_reg;
                    if (pick_a)
                    begin
                        i_next     = i_reg + CW'(1);
                        value_next = rdata_a;
                        last_next  = (i_next == cnt_a_reg) && b_done;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        value_next = rdata_b;
                        last_next  = a_done && (j_next == cnt_b_reg);
                    end
                    if (last_next)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    out_load    = 1'b1;
                    value_next  = '0;
                    last_next   = 1'b1;
                    status_next = code_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start.go)
        begin
            cnt_a_reg <= cnt_a;
            cnt_b_reg <= cnt_b;
            code_reg  <= start.code;
        end
        if (out_load)
        begin
            value_reg  <= value_next;
            last_reg   <= last_next;
            status_reg <= status_next;
        end
    end

    // next indexes drive the read ports so read data tracks the list heads
    assign raddr_a    = i_next[AW-1:0];
    assign raddr_b    = j_next[AW-1:0];

    assign busy       = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_value  = value_reg;
    assign out_last   = last_reg;
    assign out_status = status_reg;

endmodule

`default_nettype wire

/* rtl/sorted_list_merge.sv */
// ----------------------------------------------------------------------------
// sorted_list_merge
// Loads two lists of signed 32-bit values and merges them in ascending order.
//
// Input channel (in_valid/in_ready, kind, value): kind 0 appends value to
// list one, kind 1 to list two, kind 2 starts a merge, kind 3 is ignored.
// Loads into a full list are dropped and reported as overflow status on the
// next merge, unless that merge gives an error beat.
// A start passes through a memory prefetch state, then emits one beat per
// cycle on the output channel (out_valid/out_ready, value_res, last,
// status): N1+N2 beats in order, list one first on ties, last on the final
// beat. An empty or unsorted list gives one error beat instead. The input is
// held off (in_ready low) until the final beat enters the output register.
// An output stall freezes the merge; the output register holds the beat.
// Reset empties both lists and drops any pending beat. Every start clears
// both lists.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_merge #(
    parameter int LIST_DEPTH = slm_pkg::DEFAULT_LIST_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           kind,
    input  wire logic signed [31:0]   value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        value_res,
    output logic                      last,
    output logic [1:0]                status
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic [CW-1:0]        cnt_a_reg, cnt_a_next;
    logic [CW-1:0]        cnt_b_reg, cnt_b_next;
    logic                 ord_a_reg, ord_a_next;
    logic                 ord_b_reg, ord_b_next;
    logic signed [31:0]   prev_a_reg, prev_a_next;
    logic signed [31:0]   prev_b_reg, prev_b_next;
    logic                 ovf_reg, ovf_next;

    logic                 accept;
    logic                 busy;
    logic                 we_a, we_b;
    slm_pkg::start_t      start;
    logic [AW-1:0]        raddr_a, raddr_b;
    logic [31:0]          rdata_a, rdata_b;
    logic [31:0]          merge_value;

    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        ord_a_next  = ord_a_reg;
        ord_b_next  = ord_b_reg;
        prev_a_next = prev_a_reg;
        prev_b_next = prev_b_reg;
        ovf_next    = ovf_reg;
        we_a        = 1'b0;
        we_b        = 1'b0;
        start.go    = 1'b0;
        if (cnt_a_reg == '0 || cnt_b_reg == '0)
        begin
            start.code = slm_pkg::ST_EMPTY;
        end
        else if (!ord_a_reg || !ord_b_reg)
        begin
            start.code = slm_pkg::ST_UNSORTED;
        end
        else if (ovf_reg)
        begin
            start.code = slm_pkg::ST_OVERFLOW;
        end
        else
        begin
            start.code = slm_pkg::ST_OK;
        end
        if (accept)
        begin
            unique case (kind)
                slm_pkg::KIND_FIRST:
                begin
                    if (cnt_a_reg == CW'(LIST_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        we_a        = 1'b1;
                        prev_a_next = value;
                        cnt_a_next  = cnt_a_reg + CW'(1);
                        if (cnt_a_reg != '0 && prev_a_reg > value)
                        begin
                            ord_a_next = 1'b0;
                        end
                    end
                end
                slm_pkg::KIND_SECOND:
                begin
                    if (cnt_b_reg == CW'(LIST_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        we_b        = 1'b1;
                        prev_b_next = value;
                        cnt_b_next  = cnt_b_reg + CW'(1);
                        if (cnt_b_reg != '0 && prev_b_reg > value)
                        begin
                            ord_b_next = 1'b0;
                        end
                    end
                end
                slm_pkg::KIND_START:
                begin
                    start.go    = 1'b1;
                    cnt_a_next  = '0;
                    cnt_b_next  = '0;
                    ord_a_next  = 1'b1;
                    ord_b_next  = 1'b1;
                    prev_a_next = '0;
                    prev_b_next = '0;
                    ovf_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg  <= '0;
            cnt_b_reg  <= '0;
            ord_a_reg  <= 1'b1;
            ord_b_reg  <= 1'b1;
            prev_a_reg <= '0;
            prev_b_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            cnt_a_reg  <= cnt_a_next;
            cnt_b_reg  <= cnt_b_next;
            ord_a_reg  <= ord_a_next;
            ord_b_reg  <= ord_b_next;
            prev_a_reg <= prev_a_next;
            prev_b_reg <= prev_b_next;
            ovf_reg    <= ovf_next;
        end
    end

    slm_ram #(
        .WIDTH (slm_pkg::DATA_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata (value),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    slm_ram #(
        .WIDTH (slm_pkg::DATA_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata (value),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    slm_merge #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cnt_a      (cnt_a_reg),
        .cnt_b      (cnt_b_reg),
        .busy       (busy),
        .raddr_a    (raddr_a),
        .raddr_b    (raddr_b),
        .rdata_a    (rdata_a),
        .rdata_b    (rdata_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_value  (merge_value),
        .out_last   (last),
        .out_status (status)
    );

    assign value_res = merge_value;

endmodule

`default_nettype wire
